// ===== rtl/bccfr_pkg.sv =====
// ============================================================================
// bccfr_pkg : shared types and constants for the STX/ETX/BCC frame receiver
// Holds the phase encoding, register indexes, reset values and the
// structures passed between the receiver modules.
// ============================================================================
package bccfr_pkg;

    // Largest byte count before a frame is dropped as overlong
    localparam int unsigned MAX_FRAME_BYTES = 50;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned INDEX_W = 6;
    localparam int unsigned LEFT_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    // Buffer position that carries the length byte
    localparam logic [INDEX_W-1:0] LEN_INDEX = INDEX_W'(3);

    // Register indexes on the configuration channel
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_CHAR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CHAR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_END_CHAR   = 2'd2;

    localparam logic [BYTE_W-1:0] ACK_CHAR_RST   = 8'h06;
    localparam logic [BYTE_W-1:0] START_CHAR_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_CHAR_RST   = 8'h03;

    typedef enum logic [3:0] {
        PH_WAIT  = 4'b0001,
        PH_START = 4'b0010,
        PH_LEN   = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] ack_char;
        logic [BYTE_W-1:0] start_char;
        logic [BYTE_W-1:0] end_char;
    } cfg_t;

    typedef struct packed {
        logic               frame_good;
        logic               ack_pending;
        logic [BYTE_W-1:0]  store_byte;
        logic [INDEX_W-1:0] store_index;
        logic               store_valid;
    } result_t;

endpackage

// ===== rtl/bccfr_cfg.sv =====
// ============================================================================
// bccfr_cfg : configuration registers of the frame receiver
// Holds the ACK, STX and ETX byte values written over the config channel.
// ============================================================================
module bccfr_cfg
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [bccfr_pkg::CFG_INDEX_W-1:0]  wr_index,
    input  logic [bccfr_pkg::BYTE_W-1:0]       wr_data,
    output bccfr_pkg::cfg_t                    cfg
);

    bccfr_pkg::cfg_t cfg_reg;
    bccfr_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                bccfr_pkg::REG_ACK_CHAR:   cfg_next.ack_char   = wr_data;
                bccfr_pkg::REG_START_CHAR: cfg_next.start_char = wr_data;
                bccfr_pkg::REG_END_CHAR:   cfg_next.end_char   = wr_data;
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ack_char   <= bccfr_pkg::ACK_CHAR_RST;
            cfg_reg.start_char <= bccfr_pkg::START_CHAR_RST;
            cfg_reg.end_char   <= bccfr_pkg::END_CHAR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/bccfr_core.sv =====
// ============================================================================
// bccfr_core : frame parser state and per-byte decode
// Tracks phase, byte count, remaining length, running XOR and previous byte;
// advances once for every byte that moves into the result register.
// ============================================================================
module bccfr_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [bccfr_pkg::BYTE_W-1:0]  rx_byte,
    input  bccfr_pkg::cfg_t               cfg,
    output bccfr_pkg::result_t            result
);

    bccfr_pkg::phase_t                    phase_reg,  phase_next;
    logic [bccfr_pkg::INDEX_W-1:0]        count_reg,  count_next;
    logic [bccfr_pkg::LEFT_W-1:0]         left_reg,   left_next;
    logic [bccfr_pkg::BYTE_W-1:0]         xor_reg,    xor_next;
    logic [bccfr_pkg::BYTE_W-1:0]         prev_reg,   prev_next;
    logic                                 ack_reg,    ack_next;

    bccfr_pkg::phase_t                    phase_eff;
    logic [bccfr_pkg::LEFT_W-1:0]         left_dec;
    logic                                 good;

    always_comb
    begin
        // Drop an overlong frame before looking at the byte
        phase_eff = (count_reg > bccfr_pkg::INDEX_W'(bccfr_pkg::MAX_FRAME_BYTES))
                    ? bccfr_pkg::PH_WAIT : phase_reg;
        left_dec   = left_reg - bccfr_pkg::LEFT_W'(1);
        good       = 1'b0;
        phase_next = phase_eff;
        count_next = count_reg;
        left_next  = left_reg;
        xor_next   = xor_reg;
        prev_next  = prev_reg;
        ack_next   = ack_reg;

        result.store_valid = 1'b0;
        result.store_index = '0;
        result.store_byte  = '0;

        if (phase_eff == bccfr_pkg::PH_WAIT)
        begin
            if (rx_byte == cfg.ack_char)
            begin
                ack_next   = 1'b1;
                count_next = '0;
                phase_next = bccfr_pkg::PH_START;
            end
        end
        else
        begin
            result.store_valid = 1'b1;
            result.store_index = count_reg;
            result.store_byte  = rx_byte;
            count_next = count_reg + bccfr_pkg::INDEX_W'(1);
            prev_next  = rx_byte;
            xor_next   = xor_reg ^ rx_byte;

            case (phase_eff)
                bccfr_pkg::PH_START:
                begin
                    xor_next   = rx_byte;
                    phase_next = (rx_byte == cfg.start_char) ? bccfr_pkg::PH_LEN
                                                             : bccfr_pkg::PH_WAIT;
                end
                bccfr_pkg::PH_LEN:
                begin
                    if (count_reg == bccfr_pkg::LEN_INDEX)
                    begin
                        left_next  = rx_byte + bccfr_pkg::LEFT_W'(2);
                        phase_next = bccfr_pkg::PH_DATA;
                    end
                end
                bccfr_pkg::PH_DATA:
                begin
                    left_next = left_dec;
                    if (left_dec == '0)
                    begin
                        // Last byte is the BCC; the one before must be ETX
                        if (prev_reg == cfg.end_char && xor_reg == rx_byte)
                        begin
                            good     = 1'b1;
                            ack_next = 1'b0;
                        end
                        phase_next = bccfr_pkg::PH_WAIT;
                    end
                end
                default:
                begin
                    phase_next = bccfr_pkg::PH_WAIT;
                end
            endcase
        end

        result.ack_pending = ack_next;
        result.frame_good  = good;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= bccfr_pkg::PH_WAIT;
            count_reg <= '0;
            left_reg  <= '0;
            xor_reg   <= '0;
            prev_reg  <= '0;
            ack_reg   <= 1'b0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            xor_reg   <= xor_next;
            prev_reg  <= prev_next;
            ack_reg   <= ack_next;
        end
    end

endmodule

// ===== rtl/ack_stx_len_etx_bcc_frame_receiver_unit.sv =====
// ============================================================================
// ack_stx_len_etx_bcc_frame_receiver_unit : ACK/STX/LEN/ETX/BCC frame receiver
// Takes received bytes, recognizes response frames and reports every stored
// byte with its buffer index, the ack-pending flag and a frame-good pulse.
// ============================================================================
// Path: a byte accepted on s_axis waits in the input register until the result
//   register is empty or its beat is taken, then moves there and shows on m_axis.
// Throughput: one byte per cycle; the input register and the result register
//   each take a beat while the next stage holds, so only m_tready low stalls.
// Reset: rst_n clears phase to waiting for ACK, counters, XOR, ack flag and
//   both valid bits, and loads the config defaults (ACK 0x06, STX 0x02, ETX 0x03).
module ack_stx_len_etx_bcc_frame_receiver_unit
(
    input  logic        clk,
    input  logic        rst_n,

    // Received byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte

    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [0] store_valid, [6:1] store_index,
                                   // [14:7] store_byte, [15] ack_pending,
                                   // [16] frame_good, [23:17] zero

    // Configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index, // 0 ack_char, 1 start_char, 2 end_char
    input  logic [7:0]  cfg_data
);

    bccfr_pkg::cfg_t       cfg;
    bccfr_pkg::result_t    result;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  out_valid_reg;
    bccfr_pkg::result_t    out_result_reg;

    logic                  advance;

    // Writes are registered in the config block; the channel never backs up
    assign cfg_ready = 1'b1;

    bccfr_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Move a held byte into the result register whenever that register is
    // empty or its beat is being taken this cycle
    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Byte payload needs no reset
    always_ff @(posedge clk)
    begin
        if (s_tready & s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    // Parser state steps exactly once per byte that advances
    bccfr_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .rx_byte (in_byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_result_reg};

    // A good frame always clears the ack flag in the same beat
    a_good_clears_ack: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_result_reg.frame_good) |-> !out_result_reg.ack_pending)
        else $error("frame_good with ack_pending still set");

    // A good frame ends on a stored check byte
    a_good_is_stored: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_result_reg.frame_good) |-> out_result_reg.store_valid)
        else $error("frame_good on a byte that was not stored");

    // Bytes that are not stored report zero index and data
    a_nostore_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !out_result_reg.store_valid)
            |-> (out_result_reg.store_index == '0 && out_result_reg.store_byte == '0))
        else $error("unstored byte carries nonzero index or data");

    // A byte taken in while the input register is full must have advanced
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && in_valid_reg) |-> advance)
        else $error("input register overwritten before it advanced");

endmodule
